@@ rtl/assert_macros.svh @@
// assertion macros for the selection block
// each macro expects clk and rst to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfcs assertion failed");

// next-cycle implication
`define PFCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfcs assertion failed");

`endif

@@ rtl/pfcs_pkg.sv @@
// shared types and constants for the pareto front crowding selection block
// no dependencies
package pfcs_pkg;

  localparam int IN_W       = 32;
  localparam int IN_DATA_W  = 64;
  localparam int IDX_W      = 6;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_W      = 7;
  localparam int DIST_W     = 32;
  localparam int Q_FRAC     = 24;
  localparam int FRAC_CW    = 5;

  localparam logic [CFG_W-1:0]  SELECT_RESET = 7'd32;
  localparam logic [DIST_W-1:0] DIST_INF     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } out_item_t;

  typedef enum logic [20:0] {
    S_LOAD    = 21'h000001,
    S_DOM_J   = 21'h000002,
    S_DOM_L   = 21'h000004,
    S_DOM_I   = 21'h000008,
    S_FR_INIT = 21'h000010,
    S_FRONT   = 21'h000020,
    S_CZ      = 21'h000040,
    S_RK_P    = 21'h000080,
    S_RK_L    = 21'h000100,
    S_RK_Q    = 21'h000200,
    S_W_HI    = 21'h000400,
    S_W_HI1   = 21'h000800,
    S_W_HI2   = 21'h001000,
    S_W_OB    = 21'h002000,
    S_W_PT    = 21'h004000,
    S_W_KEY   = 21'h008000,
    S_W_DIV   = 21'h010000,
    S_W_ADD   = 21'h020000,
    S_PK_INIT = 21'h040000,
    S_PK      = 21'h080000,
    S_OUT     = 21'h100000
  } state_t;

endpackage

@@ rtl/pareto_front_crowding_select.sv @@
// Pareto front selection with crowding-distance cut over a loaded population.
// Input stream: one point per request, tdata = x (bits 31:0), y (63:32),
// tlast marks the last point. Points load at one per cycle; tready is high
// only while loading. Points past MAX_POINTS are dropped; a dropped last
// point still starts selection.
// After the last point the block works alone, tready low: it builds the
// domination rows, peels one front per round, and for the cut front ranks
// the members on each axis, sums crowding ratios of the inner points with a
// 24-step ratio divider and picks the needed members by largest distance,
// then emits the chosen indices in ascending order, one per cycle at best,
// tlast on the final one. Points, domination rows, sorted order and
// distances live in single-port-read memories with registered reads, so
// every scan steps through the points in index order.
// A stalled receiver holds the output register and pauses emission; the
// next population may start loading while the final index still waits.
// Reset (synchronous): select_count back to 32, loader empty, output idle.
// select_count (cfg_wdata) may be written only while the block is idle.
module pareto_front_crowding_select #(
  parameter int MAX_POINTS = 64,
  parameter int OBJ_WIDTH  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pfcs_pkg::CFG_W-1:0]       cfg_wdata,      // select_count
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pfcs_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // x_value, y_value
  input  logic                             s_axis_tlast,   // last_point
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pfcs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // point_index, pad
  output logic                             m_axis_tlast    // last_index
);
  import pfcs_pkg::*;

  localparam int W  = OBJ_WIDTH;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = (OBJ_WIDTH < IN_W) ? OBJ_WIDTH : IN_W;
  localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);

  // memories
  logic [2*W-1:0]        pt_mem   [MAX_POINTS];
  logic [MAX_POINTS-1:0] dom_mem  [MAX_POINTS];
  logic [AW-1:0]         ob_mem   [MAX_POINTS];
  logic [DIST_W-1:0]     dist_mem [MAX_POINTS];

  logic [2*W-1:0]        rd_pt;
  logic [MAX_POINTS-1:0] rd_dom;
  logic [AW-1:0]         rd_ob;
  logic [DIST_W-1:0]     rd_dist;

  logic [AW-1:0]         ra_pt, ra_dom, ra_ob, ra_dist;
  logic                  pt_we, dom_we, ob_we, dist_we;
  logic [AW-1:0]         dist_wa;
  logic [DIST_W-1:0]     dist_wd;

  state_t                state;
  logic [CFG_W-1:0]      sel_cnt;
  logic [CW-1:0]         cnt, cnt_new, n, m, selected, fc, need;
  logic [CW-1:0]         i, j, p, k, rank, e;
  logic [AW-1:0]         pidx, mid, fidx, k1_idx, best;
  logic                  pv, axis, have;
  logic [2*W-1:0]        pj;
  logic [W-1:0]          pk, hi_key, lo_key, k1_key, k2_key;
  logic [MAX_POINTS-1:0] row, removed, front, sel_flags, taken;
  logic [DIST_W-1:0]     best_d;

  logic                  acc, scan_done, is_dom, rk_less, front_bit;
  logic [W-1:0]          pt_x, pt_y, pt_key, rd_x, rd_y;
  logic [MAX_POINTS-1:0] best_hot, e_hot;
  logic [DIST_W:0]       sum;

  logic                  div_start, div_done;
  logic [DIST_W-1:0]     div_q;

  logic                  push, push_ready;
  out_item_t             push_item, out_item;

  assign acc       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_LOAD);
  assign cnt_new   = (cnt != MAXP) ? cnt + 1'b1 : cnt;
  assign scan_done = (i == n) && !pv;

  assign pt_x   = rd_pt[W-1:0];
  assign pt_y   = rd_pt[2*W-1:W];
  assign pt_key = axis ? pt_y : pt_x;
  assign rd_x   = pj[W-1:0];
  assign rd_y   = pj[2*W-1:W];

  // point at pidx dominates the held point pj
  assign is_dom = (pt_x <= rd_x) && (pt_y <= rd_y) && ((pt_x < rd_x) || (pt_y < rd_y));
  assign rk_less = front[pidx] &&
                   ((pt_key < pk) || ((pt_key == pk) && (CW'(pidx) < p)));
  assign front_bit = !removed[pidx] && ((rd_dom & ~removed) == '0);

  assign best_hot = MAX_POINTS'(1) << best;
  assign e_hot    = MAX_POINTS'(1) << e[AW-1:0];
  assign sum      = {1'b0, rd_dist} + {1'b0, div_q};

  assign div_start = (state == S_W_KEY) && (k >= CW'(2)) && (hi_key != lo_key);

  always_comb begin
    ra_pt = '0;
    case (state)
      S_DOM_J:           ra_pt = j[AW-1:0];
      S_DOM_I, S_RK_Q:   ra_pt = i[AW-1:0];
      S_RK_P:            ra_pt = p[AW-1:0];
      S_W_HI1, S_W_PT:   ra_pt = rd_ob;
      default:           ra_pt = '0;
    endcase
    ra_dom  = i[AW-1:0];
    ra_ob   = (state == S_W_HI) ? AW'(fc - 1'b1) : k[AW-1:0];
    ra_dist = (state == S_PK) ? i[AW-1:0] : mid;
  end

  always_comb begin
    pt_we   = acc && (cnt != MAXP);
    dom_we  = (state == S_DOM_I) && scan_done;
    ob_we   = (state == S_RK_Q) && scan_done;
    dist_we = 1'b0;
    dist_wa = mid;
    dist_wd = DIST_INF;
    case (state)
      S_CZ: begin
        dist_we = (p != n);
        dist_wa = p[AW-1:0];
        dist_wd = '0;
      end
      S_W_HI2: begin
        dist_we = 1'b1;
        dist_wa = fidx;
      end
      S_W_KEY: begin
        dist_we = (k == '0);
        dist_wa = fidx;
      end
      S_W_ADD: begin
        dist_we = 1'b1;
        dist_wa = mid;
        dist_wd = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
      end
      default: dist_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[cnt[AW-1:0]] <= {W'(s_axis_tdata[IN_W+IW-1:IN_W]), W'(s_axis_tdata[IW-1:0])};
    end
    rd_pt <= pt_mem[ra_pt];
  end

  always_ff @(posedge clk) begin
    if (dom_we) begin
      dom_mem[j[AW-1:0]] <= row;
    end
    rd_dom <= dom_mem[ra_dom];
  end

  always_ff @(posedge clk) begin
    if (ob_we) begin
      ob_mem[rank[AW-1:0]] <= p[AW-1:0];
    end
    rd_ob <= ob_mem[ra_ob];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    rd_dist <= dist_mem[ra_dist];
  end

  always_comb begin
    push           = 1'b0;
    push_item.idx  = IDX_W'(e[AW-1:0]);
    push_item.last = ((sel_flags & ~e_hot) == '0);
    if (state == S_OUT && e != n && sel_flags[e[AW-1:0]]) begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_cnt <= SELECT_RESET;
    end else if (cfg_we) begin
      sel_cnt <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
      pv    <= 1'b0;
      e     <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          e <= '0;
          if (acc) begin
            if (s_axis_tlast) begin
              n         <= cnt_new;
              m         <= (sel_cnt < CFG_W'(cnt_new)) ? CW'(sel_cnt) : cnt_new;
              selected  <= '0;
              removed   <= '0;
              sel_flags <= '0;
              j         <= '0;
              state     <= S_DOM_J;
            end else begin
              cnt <= cnt_new;
            end
          end
        end
        S_DOM_J: state <= S_DOM_L;
        S_DOM_L: begin
          pj    <= rd_pt;
          row   <= '0;
          i     <= '0;
          pv    <= 1'b0;
          state <= S_DOM_I;
        end
        S_DOM_I: begin
          if (i != n) begin
            i    <= i + 1'b1;
            pv   <= 1'b1;
            pidx <= i[AW-1:0];
          end else begin
            pv <= 1'b0;
          end
          if (pv && is_dom) begin
            row[pidx] <= 1'b1;
          end
          if (scan_done) begin
            j     <= j + 1'b1;
            state <= (j + 1'b1 == n) ? S_FR_INIT : S_DOM_J;
          end
        end
        S_FR_INIT: begin
          i     <= '0;
          pv    <= 1'b0;
          fc    <= '0;
          front <= '0;
          state <= (selected >= m) ? S_OUT : S_FRONT;
        end
        S_FRONT: begin
          if (i != n) begin
            i    <= i + 1'b1;
            pv   <= 1'b1;
            pidx <= i[AW-1:0];
          end else begin
            pv <= 1'b0;
          end
          if (pv && front_bit) begin
            front[pidx] <= 1'b1;
            fc          <= fc + 1'b1;
          end
          if (scan_done) begin
            if (fc == '0) begin
              state <= S_OUT;
            end else if (selected + fc > m) begin
              need  <= m - selected;
              taken <= '0;
              p     <= '0;
              state <= S_CZ;
            end else begin
              sel_flags <= sel_flags | front;
              removed   <= removed | front;
              selected  <= selected + fc;
              state     <= S_FR_INIT;
            end
          end
        end
        S_CZ: begin
          if (p != n) begin
            p <= p + 1'b1;
          end else begin
            p     <= '0;
            axis  <= 1'b0;
            state <= S_RK_P;
          end
        end
        S_RK_P: begin
          if (p == n) begin
            state <= S_W_HI;
          end else if (front[p[AW-1:0]]) begin
            state <= S_RK_L;
          end else begin
            p <= p + 1'b1;
          end
        end
        S_RK_L: begin
          pk    <= pt_key;
          rank  <= '0;
          i     <= '0;
          pv    <= 1'b0;
          state <= S_RK_Q;
        end
        S_RK_Q: begin
          if (i != n) begin
            i    <= i + 1'b1;
            pv   <= 1'b1;
            pidx <= i[AW-1:0];
          end else begin
            pv <= 1'b0;
          end
          if (pv && rk_less) begin
            rank <= rank + 1'b1;
          end
          if (scan_done) begin
            p     <= p + 1'b1;
            state <= S_RK_P;
          end
        end
        S_W_HI:  state <= S_W_HI1;
        S_W_HI1: begin
          fidx  <= rd_ob;
          state <= S_W_HI2;
        end
        S_W_HI2: begin
          hi_key <= pt_key;
          k      <= '0;
          state  <= S_W_OB;
        end
        S_W_OB: state <= S_W_PT;
        S_W_PT: begin
          fidx  <= rd_ob;
          state <= S_W_KEY;
        end
        S_W_KEY: begin
          if (k == '0) begin
            lo_key <= pt_key;
          end
          // slide the window of the last three sorted members
          k2_key <= k1_key;
          k1_key <= pt_key;
          k1_idx <= fidx;
          mid    <= k1_idx;
          k      <= k + 1'b1;
          if (div_start) begin
            state <= S_W_DIV;
          end else if (k + 1'b1 == fc) begin
            p     <= '0;
            axis  <= 1'b1;
            state <= axis ? S_PK_INIT : S_RK_P;
          end else begin
            state <= S_W_OB;
          end
        end
        S_W_DIV: begin
          if (div_done) begin
            state <= S_W_ADD;
          end
        end
        S_W_ADD: begin
          if (k == fc) begin
            p     <= '0;
            axis  <= 1'b1;
            state <= axis ? S_PK_INIT : S_RK_P;
          end else begin
            state <= S_W_OB;
          end
        end
        S_PK_INIT: begin
          i     <= '0;
          pv    <= 1'b0;
          have  <= 1'b0;
          state <= S_PK;
        end
        S_PK: begin
          if (i != n) begin
            i    <= i + 1'b1;
            pv   <= 1'b1;
            pidx <= i[AW-1:0];
          end else begin
            pv <= 1'b0;
          end
          // strict compare in index order keeps ties on the lower index
          if (pv && front[pidx] && !taken[pidx] && (!have || rd_dist > best_d)) begin
            have   <= 1'b1;
            best   <= pidx;
            best_d <= rd_dist;
          end
          if (scan_done) begin
            taken <= taken | best_hot;
            need  <= need - 1'b1;
            if (need == CW'(1)) begin
              sel_flags <= sel_flags | taken | best_hot;
              state     <= S_OUT;
            end else begin
              state <= S_PK_INIT;
            end
          end
        end
        S_OUT: begin
          if (e == n) begin
            cnt   <= '0;
            state <= S_LOAD;
          end else if (!sel_flags[e[AW-1:0]]) begin
            e <= e + 1'b1;
          end else if (push_ready) begin
            sel_flags[e[AW-1:0]] <= 1'b0;
            e                    <= e + 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  pfcs_ratio_div #(
    .W (W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (pt_key - k2_key),
    .den   (hi_key - lo_key),
    .done  (div_done),
    .quot  (div_q)
  );

  pfcs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_ready  (push_ready),
    .in_item   (push_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_item.idx);
  assign m_axis_tlast = out_item.last;

  `include "assert_macros.svh"

  `PFCS_ASSERT_NXT(a_last_starts_sort, acc && s_axis_tlast, state == S_DOM_J)
  `PFCS_ASSERT_IMP(a_selected_bounded, state == S_FR_INIT, selected <= m)
  `PFCS_ASSERT_IMP(a_pick_found, (state == S_PK) && (i == n) && !pv, have)

endmodule

@@ rtl/pfcs_ratio_div.sv @@
// iterative restoring divider giving num/den in unsigned q8.24, num <= den
// depends on pfcs_pkg
module pfcs_ratio_div #(
  parameter int W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [W-1:0]               num,
  input  logic [W-1:0]               den,
  output logic                       done,
  output logic [pfcs_pkg::DIST_W-1:0] quot
);
  import pfcs_pkg::*;

  logic               busy;
  logic [FRAC_CW-1:0] cnt;
  logic [W-1:0]       rem;
  logic [W-1:0]       den_r;
  logic [Q_FRAC:0]    q;
  logic [W:0]         sh;
  logic               ge;

  assign sh   = {rem, 1'b0};
  assign ge   = sh >= {1'b0, den_r};
  assign quot = DIST_W'(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // whole part is one only when num equals den
        rem   <= (num >= den) ? '0 : num;
        q     <= (Q_FRAC+1)'(num >= den);
        den_r <= den;
        cnt   <= FRAC_CW'(Q_FRAC);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= ge ? W'(sh - {1'b0, den_r}) : W'(sh);
        q   <= {q[Q_FRAC-1:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == FRAC_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/pfcs_out_reg.sv @@
// output register stage holding one selected index request
// depends on pfcs_pkg
module pfcs_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pfcs_pkg::out_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output pfcs_pkg::out_item_t out_item
);
  import pfcs_pkg::*;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= in_item;
    end
  end

endmodule
